FILE: hw/rtl/pstd_pkg.sv
// ----------------------------------------------------------------------------
// pstd_pkg
// Shared widths, codes and types for the percent swing trend detector.
// ----------------------------------------------------------------------------
package pstd_pkg;

   localparam int SAMPLE_BITS = 32;
   localparam int BP_BITS     = 14;
   localparam int FACTOR_BITS = BP_BITS + 1;
   localparam int PROD_BITS   = SAMPLE_BITS + FACTOR_BITS;

   localparam logic [BP_BITS-1:0]     BP_FULL  = BP_BITS'(10000);
   localparam logic [BP_BITS-1:0]     BP_RESET = BP_BITS'(500);

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [1:0]      trend_type;

   localparam trend_type TREND_NEUTRAL = 2'sb00;
   localparam trend_type TREND_UP      = 2'sb01;
   localparam trend_type TREND_DOWN    = 2'sb11;

   typedef struct packed {
      sample_type sample;
      logic       sample_missing;
      logic       series_start;
   } item_type;

   typedef struct packed {
      trend_type trend;
      logic      result_empty;
   } result_type;

   typedef struct packed {
      logic [FACTOR_BITS-1:0] upper_factor;
      logic [FACTOR_BITS-1:0] lower_factor;
   } threshold_type;

endpackage

FILE: hw/rtl/pstd_channels.sv
// ----------------------------------------------------------------------------
// pstd_channels
// Valid/ready channels for samples, trend results and the threshold write.
// ----------------------------------------------------------------------------
interface pstd_req_if import pstd_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample;
   logic       sample_missing;
   logic       series_start;

   modport source (output valid, sample, sample_missing, series_start, input ready);
   modport sink   (input valid, sample, sample_missing, series_start, output ready);
endinterface

interface pstd_rsp_if import pstd_pkg::*; ();
   logic      valid;
   logic      ready;
   trend_type trend;
   logic      result_empty;

   modport source (output valid, trend, result_empty, input ready);
   modport sink   (input valid, trend, result_empty, output ready);
endinterface

interface pstd_csr_if import pstd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [BP_BITS-1:0] reversal_basis_points;

   modport source (output valid, reversal_basis_points, input ready);
   modport sink   (input valid, reversal_basis_points, output ready);
endinterface

FILE: hw/rtl/pstd_threshold.sv
// ----------------------------------------------------------------------------
// pstd_threshold
// Threshold register; saturates at full scale and keeps the two
// cross-multiplication factors (full +/- threshold) ready for the compare.
// ----------------------------------------------------------------------------
module pstd_threshold import pstd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_valid,
   input  logic [BP_BITS-1:0] wr_data,
   output threshold_type      thresh
);

   logic [BP_BITS-1:0]     bp_sat;
   logic [FACTOR_BITS-1:0] upper_ff, upper_in;
   logic [FACTOR_BITS-1:0] lower_ff, lower_in;

   assign bp_sat   = (wr_data > BP_FULL) ? BP_FULL : wr_data;
   assign upper_in = FACTOR_BITS'(BP_FULL) + FACTOR_BITS'(bp_sat);
   assign lower_in = FACTOR_BITS'(BP_FULL) - FACTOR_BITS'(bp_sat);

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff <= FACTOR_BITS'(BP_FULL) + FACTOR_BITS'(BP_RESET);
         lower_ff <= FACTOR_BITS'(BP_FULL) - FACTOR_BITS'(BP_RESET);
      end else if (wr_valid) begin
         upper_ff <= upper_in;
         lower_ff <= lower_in;
      end
   end

   assign thresh.upper_factor = upper_ff;
   assign thresh.lower_factor = lower_ff;

`ifndef NO_ASSERTIONS
   a_factor_sum: assert property (@(posedge clock) disable iff (reset)
      (PROD_BITS'(upper_ff) + PROD_BITS'(lower_ff)) == PROD_BITS'(2 * 10000))
      else $error("threshold factors out of step");
   a_lower_range: assert property (@(posedge clock) disable iff (reset)
      lower_ff <= FACTOR_BITS'(BP_FULL))
      else $error("lower factor above full scale");
   a_write_takes: assert property (@(posedge clock) disable iff (reset)
      wr_valid && wr_data <= BP_FULL |=> upper_ff == FACTOR_BITS'(BP_FULL) +
      FACTOR_BITS'($past(wr_data)))
      else $error("threshold write lost");
`endif

endmodule

FILE: hw/rtl/pstd_core.sv
// ----------------------------------------------------------------------------
// pstd_core
// Series state and one-item trend decision by cross-multiplied compares.
// ----------------------------------------------------------------------------
module pstd_core import pstd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  item_type      item,
   input  threshold_type thresh,
   output result_type    result
);

   logic       seen_ff, seen_in;
   trend_type  trend_ff, trend_in;
   sample_type ext_ff, ext_in;

   logic       eff_seen;
   trend_type  eff_trend;
   sample_type eff_ext;

   logic [PROD_BITS-1:0] scaled_cur;
   logic [PROD_BITS-1:0] upper;
   logic [PROD_BITS-1:0] lower;

   // series start clears the state before the item is used
   assign eff_seen  = item.series_start ? 1'b0 : seen_ff;
   assign eff_trend = item.series_start ? TREND_NEUTRAL : trend_ff;
   assign eff_ext   = item.series_start ? '0 : ext_ff;

   assign scaled_cur = PROD_BITS'(item.sample) * PROD_BITS'(BP_FULL);
   assign upper      = PROD_BITS'(eff_ext) * PROD_BITS'(thresh.upper_factor);
   assign lower      = PROD_BITS'(eff_ext) * PROD_BITS'(thresh.lower_factor);

   always_comb begin
      seen_in             = eff_seen;
      trend_in            = eff_trend;
      ext_in              = eff_ext;
      result.trend        = TREND_NEUTRAL;
      result.result_empty = 1'b0;
      if (item.sample_missing) begin
         result.trend        = eff_seen ? eff_trend : TREND_NEUTRAL;
         result.result_empty = !eff_seen;
      end else if (!eff_seen) begin
         seen_in  = 1'b1;
         trend_in = TREND_NEUTRAL;
         ext_in   = item.sample;
      end else begin
         case (eff_trend)
            TREND_NEUTRAL: begin
               if (scaled_cur > upper) begin
                  trend_in = TREND_UP;
                  ext_in   = item.sample;
               end else if (scaled_cur < lower) begin
                  trend_in = TREND_DOWN;
                  ext_in   = item.sample;
               end
            end
            TREND_DOWN: begin
               if (item.sample <= eff_ext) begin
                  ext_in = item.sample;
               end else if (scaled_cur >= upper) begin
                  trend_in = TREND_UP;
                  ext_in   = item.sample;
               end
            end
            TREND_UP: begin
               if (item.sample >= eff_ext) begin
                  ext_in = item.sample;
               end else if (scaled_cur <= lower) begin
                  trend_in = TREND_DOWN;
                  ext_in   = item.sample;
               end
            end
            default: begin
            end
         endcase
         result.trend = trend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= 1'b0;
         trend_ff <= TREND_NEUTRAL;
         ext_ff   <= '0;
      end else if (step) begin
         seen_ff  <= seen_in;
         trend_ff <= trend_in;
         ext_ff   <= ext_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_empty_neutral: assert property (@(posedge clock) disable iff (reset)
      step && result.result_empty |-> result.trend == TREND_NEUTRAL)
      else $error("empty result with a trend");
   a_real_sets_seen: assert property (@(posedge clock) disable iff (reset)
      step && !item.sample_missing |=> seen_ff)
      else $error("real sample not recorded");
   a_first_extreme: assert property (@(posedge clock) disable iff (reset)
      step && !item.sample_missing && !eff_seen |=>
      ext_ff == $past(item.sample) && trend_ff == TREND_NEUTRAL)
      else $error("first sample did not set the extreme");
   a_unseen_neutral: assert property (@(posedge clock) disable iff (reset)
      !seen_ff |-> trend_ff == TREND_NEUTRAL)
      else $error("trend without a sample");
`endif

endmodule

FILE: hw/rtl/percent_swing_trend_detector.sv
// Path: a sample taken on req waits in the input register; the core's result
//   goes to the result register, from which it is offered on rsp.
// Throughput: one sample per cycle unless rsp stalls; the state update and two
//   32x15 multiplies and compares fit between the input and result registers.
// Reset: synchronous, active high; clears the series state, empties both
//   registers and loads the threshold with 500 basis points.
// ----------------------------------------------------------------------------
// percent_swing_trend_detector
// Zigzag-style percent reversal trend detector with a threshold register.
// ----------------------------------------------------------------------------
module percent_swing_trend_detector import pstd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   pstd_req_if.sink   req_if,
   pstd_rsp_if.source rsp_if,
   pstd_csr_if.sink   csr_if
);

   logic          in_valid_ff, in_valid_in;
   item_type      in_item_ff;
   logic          out_valid_ff, out_valid_in;
   result_type    out_result_ff;
   logic          advance;
   logic          req_xfer;
   threshold_type thresh;
   result_type    core_result;

   assign advance     = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_xfer    = req_if.valid && req_if.ready;
   assign req_if.ready = !in_valid_ff || advance;
   assign in_valid_in  = req_xfer || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_item_ff.sample         <= req_if.sample;
         in_item_ff.sample_missing <= req_if.sample_missing;
         in_item_ff.series_start   <= req_if.series_start;
      end
      if (advance) begin
         out_result_ff <= core_result;
      end
   end

   assign csr_if.ready = 1'b1;

   pstd_threshold u_threshold (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_if.valid),
      .wr_data  (csr_if.reversal_basis_points),
      .thresh   (thresh)
   );

   pstd_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .thresh (thresh),
      .result (core_result)
   );

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.trend        = out_result_ff.trend;
   assign rsp_if.result_empty = out_result_ff.result_empty;

`ifndef NO_ASSERTIONS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_if.ready |=> out_valid_ff && $stable(out_result_ff))
      else $error("stalled result overwritten");
   a_item_moves: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("processed sample produced no result");
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_item_ff))
      else $error("waiting sample lost");
`endif

endmodule
